### design/psl_pkg.sv
// Shared constants, codes and types for the positional shift list.
package psl_pkg;

    // List geometry
    localparam int CAPACITY   = 128;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (CNT_W > 8) ? CNT_W : 8;

    // Read-back OR tree: cells are gathered in registered groups
    localparam int GROUP_SIZE = 16;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    // Request function codes
    localparam logic [2:0] FN_INS_POS   = 3'd0;
    localparam logic [2:0] FN_INS_FRONT = 3'd1;
    localparam logic [2:0] FN_INS_END   = 3'd2;
    localparam logic [2:0] FN_REM_POS   = 3'd3;
    localparam logic [2:0] FN_REM_FRONT = 3'd4;
    localparam logic [2:0] FN_REM_END   = 3'd5;
    localparam logic [2:0] FN_READ      = 3'd6;

    // Cell operations
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_UP   = 2'd1;
    localparam logic [1:0] CELL_DOWN = 2'd2;

    typedef logic [DATA_WIDTH-1:0] entry_t;

    // Control broadcast to every cell
    typedef struct packed {
        logic [1:0]       op;
        logic [CNT_W-1:0] pos;
        entry_t           data;
        logic             tap_en;
    } cell_ctl_t;

endpackage

### design/psl_req_if.sv
// Request channel: function, position and entry to insert.
interface psl_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [7:0]  position;
    logic [31:0] entry_data;

    modport source (output valid, output func, output position, output entry_data,
                    input ready);
    modport sink   (input valid, input func, input position, input entry_data,
                    output ready);
endinterface

### design/psl_rsp_if.sv
// Response channel: status, returned entry and entry count.
interface psl_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [31:0] data_out;
    logic [7:0]  entry_count;

    modport source (output valid, output status, output data_out, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input data_out, input entry_count,
                    output ready);
endinterface

### design/positional_shift_list.sv
// Top level of the positional shift list: request decode, cell chain, response register.
//
//   channel  dir  fields                          accepted when
//   req      in   func, position, entry_data      req.valid && req.ready
//   rsp      out  status, data_out, entry_count   rsp.valid && rsp.ready
//
// Each request is accepted and decoded in the idle state; in the shift step every
// cell shifts, loads or holds while the selected entry is captured into the
// group registers of the OR tree; the done step then loads the response register.
// A stalled response holds the block in its last step; the next request is
// taken once the response register has room. Reset empties the list at once;
// cell contents are not cleared.
module positional_shift_list (
    input  logic     clk,
    input  logic     rst_n,
    psl_req_if.sink  req,
    psl_rsp_if.source rsp
);
    import psl_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    cell_ctl_t        ctl_reg;
    cell_ctl_t        ctl_next;
    cell_ctl_t        ctl_live;
    logic             err_reg;
    logic             err_next;
    logic [CNT_W-1:0] count_reg;
    logic             out_valid_reg;
    logic             out_status_reg;
    logic [31:0]      out_data_reg;
    logic [7:0]       out_count_reg;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] eff_pos;
    logic             accept;
    logic             out_load;

    entry_t           cell_val [CAPACITY];
    entry_t           cell_tap [CAPACITY];
    entry_t           picked;

    assign accept   = req.valid && req.ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);
    assign req.ready = (state_reg == ST_IDLE);

    // Request decode: effective position, error check, cell operation
    always_comb
    begin
        pos_ext  = CMP_W'(req.position);
        cnt_ext  = CMP_W'(count_reg);
        eff_pos  = pos_ext;
        err_next = 1'b0;
        ctl_next.op     = CELL_HOLD;
        ctl_next.tap_en = 1'b0;
        ctl_next.data   = DATA_WIDTH'(req.entry_data);
        unique case (req.func) inside
            FN_INS_POS, FN_INS_FRONT, FN_INS_END:
            begin
                if (req.func == FN_INS_FRONT)
                    eff_pos = '0;
                else if (req.func == FN_INS_END)
                    eff_pos = cnt_ext;
                err_next    = (count_reg == CNT_W'(CAPACITY)) || (eff_pos > cnt_ext);
                ctl_next.op = CELL_UP;
            end
            FN_REM_POS, FN_REM_FRONT, FN_REM_END:
            begin
                if (req.func == FN_REM_FRONT)
                    eff_pos = '0;
                else if (req.func == FN_REM_END)
                    eff_pos = cnt_ext - CMP_W'(1);
                err_next        = (count_reg == '0) || (eff_pos >= cnt_ext);
                ctl_next.op     = CELL_DOWN;
                ctl_next.tap_en = 1'b1;
            end
            FN_READ:
            begin
                err_next        = (eff_pos >= cnt_ext);
                ctl_next.tap_en = 1'b1;
            end
            default:
            begin
                err_next = 1'b1;
            end
        endcase
        ctl_next.pos = eff_pos[CNT_W-1:0];
        if (err_next)
        begin
            ctl_next.op     = CELL_HOLD;
            ctl_next.tap_en = 1'b0;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_SHIFT;
            ST_SHIFT: state_next = ST_DONE;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SHIFT)
            begin
                if (ctl_reg.op == CELL_UP)
                    count_reg <= count_reg + CNT_W'(1);
                else if (ctl_reg.op == CELL_DOWN)
                    count_reg <= count_reg - CNT_W'(1);
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Request and response payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl_reg <= ctl_next;
            err_reg <= err_next;
        end
        if (out_load)
        begin
            out_status_reg <= err_reg;
            out_data_reg   <= err_reg ? 32'd0 : 32'(picked);
            out_count_reg  <= 8'(count_reg);
        end
    end

    // Cells act only during the shift step
    always_comb
    begin
        ctl_live = ctl_reg;
        if (state_reg != ST_SHIFT)
            ctl_live.op = CELL_HOLD;
    end

    // Chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t lower_w;
        entry_t upper_w;

        if (i == 0)
        begin : g_first
            assign lower_w = '0;
        end
        else
        begin : g_mid_lo
            assign lower_w = cell_val[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper_w = cell_val[i];
        end
        else
        begin : g_mid_hi
            assign upper_w = cell_val[i+1];
        end

        psl_cell u_cell (
            .clk   (clk),
            .idx   (CNT_W'(i)),
            .ctl   (ctl_live),
            .lower (lower_w),
            .upper (upper_w),
            .value (cell_val[i]),
            .tap   (cell_tap[i])
        );
    end

    psl_collect u_collect (
        .clk     (clk),
        .capture (state_reg == ST_SHIFT),
        .taps    (cell_tap),
        .data    (picked)
    );

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.data_out    = out_data_reg;
    assign rsp.entry_count = out_count_reg;

endmodule

### design/psl_cell.sv
// One list cell: holds an entry, shifts from a neighbor, loads or holds.
module psl_cell (
    input  logic                    clk,
    input  logic [psl_pkg::CNT_W-1:0] idx,
    input  psl_pkg::cell_ctl_t      ctl,
    input  psl_pkg::entry_t         lower,
    input  psl_pkg::entry_t         upper,
    output psl_pkg::entry_t         value,
    output psl_pkg::entry_t         tap
);
    import psl_pkg::*;

    entry_t value_reg;
    entry_t value_next;

    // Next entry: open a slot at pos or close the gap at pos
    always_comb
    begin
        value_next = value_reg;
        case (ctl.op)
            CELL_UP:
            begin
                if (idx == ctl.pos)
                    value_next = ctl.data;
                else if (idx > ctl.pos)
                    value_next = lower;
            end
            CELL_DOWN:
            begin
                if (idx >= ctl.pos)
                    value_next = upper;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // Selected cell drives its entry onto the read-back tree
    assign value = value_reg;
    assign tap   = (ctl.tap_en && (idx == ctl.pos)) ? value_reg : '0;

endmodule

### design/psl_collect.sv
// Registered OR tree that gathers the one selected cell entry.
module psl_collect (
    input  logic            clk,
    input  logic            capture,
    input  psl_pkg::entry_t taps [psl_pkg::CAPACITY],
    output psl_pkg::entry_t data
);
    import psl_pkg::*;

    entry_t group_reg  [NUM_GROUPS];
    entry_t group_next [NUM_GROUPS];

    // First level: OR within each group of cells
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if (g * GROUP_SIZE + k < CAPACITY)
                    group_next[g] = group_next[g] | taps[g * GROUP_SIZE + k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
                group_reg[g] <= group_next[g];
        end
    end

    // Second level: OR across groups
    always_comb
    begin
        data = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
            data = data | group_reg[g];
    end

endmodule

### sim/testbench.sv
// Self-checking testbench for the positional shift list: directed and random requests.
module testbench;
    import psl_pkg::*;

    localparam logic [2:0] FN_UNUSED  = 3'd7;
    localparam int         IDLE_PCT   = 14;
    localparam int         RAND_ITEMS = 1350;
    localparam int         STALL_LIMIT = 2000;
    localparam int         DRAIN_CYCLES = 16;

    typedef struct packed {
        logic       status;
        entry_t     data;
        logic [7:0] count;
    } list_rsp_t;

    // Shadow copy of the list plus the responses still owed by the block
    class list_scoreboard;
        entry_t    shadow_list[$];
        list_rsp_t awaited_responses[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // Apply one accepted request to the shadow list and queue its response
        function void note_request(logic [2:0] fn, logic [7:0] position, entry_t value);
            int        n;
            int        idx;
            list_rsp_t r;
            n   = shadow_list.size();
            idx = int'(position);
            r   = '0;
            case (fn)
                FN_INS_POS, FN_INS_FRONT, FN_INS_END:
                begin
                    if (fn == FN_INS_FRONT)
                        idx = 0;
                    else if (fn == FN_INS_END)
                        idx = n;
                    if (n >= CAPACITY || idx > n)
                        r.status = 1'b1;
                    else
                        shadow_list.insert(idx, value);
                end
                FN_REM_POS, FN_REM_FRONT, FN_REM_END:
                begin
                    if (n == 0)
                        r.status = 1'b1;
                    else
                    begin
                        if (fn == FN_REM_FRONT)
                            idx = 0;
                        else if (fn == FN_REM_END)
                            idx = n - 1;
                        if (idx >= n)
                            r.status = 1'b1;
                        else
                        begin
                            r.data = shadow_list[idx];
                            shadow_list.delete(idx);
                        end
                    end
                end
                FN_READ:
                begin
                    if (idx >= n)
                        r.status = 1'b1;
                    else
                        r.data = shadow_list[idx];
                end
                default:
                    r.status = 1'b1;
            endcase
            r.count = 8'(shadow_list.size());
            awaited_responses.push_back(r);
        endfunction

        // Compare one accepted response with the oldest one owed
        function void check_response(logic status, entry_t data, logic [7:0] cnt);
            list_rsp_t want;
            if (awaited_responses.size() == 0)
            begin
                $display("%0t: unexpected response status %0d data %h count %0d",
                         $time, status, data, cnt);
                errors++;
                return;
            end
            want = awaited_responses.pop_front();
            if (status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                errors++;
            end
            if (data !== want.data)
            begin
                $display("%0t: data_out expected %h actual %h", $time, want.data, data);
                errors++;
            end
            if (cnt !== want.count)
            begin
                $display("%0t: entry_count expected %0d actual %0d", $time, want.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic steady;     // no idling on either side while set
    logic filling;    // random part leans toward inserts while set
    int   quiet_cycles;

    list_scoreboard sb;

    psl_req_if req_ch();
    psl_rsp_if rsp_ch();

    positional_shift_list uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Drive one request, with random idle cycles ahead of it
    task automatic send_request(logic [2:0] fn, logic [7:0] position, entry_t value);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= fn;
        req_ch.position   <= position;
        req_ch.entry_data <= value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(fn, position, value);
    endtask

    // Pick one random request, biased to walk the list between empty and full
    task automatic send_random_request();
        int          n;
        int          r;
        int          pick;
        logic [2:0]  fn;
        logic [7:0]  position;
        entry_t      value;
        n = sb.shadow_list.size();
        if (n == CAPACITY && $urandom_range(3) == 0)
            filling = 1'b0;
        else if (n == 0 && $urandom_range(3) == 0)
            filling = 1'b1;
        r = $urandom_range(99);
        if (r < 3)
            fn = FN_UNUSED;
        else if (r < (filling ? 68 : 28))
        begin
            pick = $urandom_range(2);
            fn = (pick == 0) ? FN_INS_POS : (pick == 1) ? FN_INS_FRONT : FN_INS_END;
        end
        else if (r < 85)
        begin
            pick = $urandom_range(2);
            fn = (pick == 0) ? FN_REM_POS : (pick == 1) ? FN_REM_FRONT : FN_REM_END;
        end
        else
            fn = FN_READ;
        // Positions: mostly in range, some at the boundary, a few anywhere
        pick = $urandom_range(9);
        if (pick == 0)
            position = 8'($urandom_range(255));
        else if (pick == 1)
            position = 8'(n + 1);
        else if (pick == 2)
            position = 8'(n);
        else
            position = 8'($urandom_range(n));
        pick = $urandom_range(19);
        if (pick == 0)
            value = '0;
        else if (pick == 1)
            value = '1;
        else
            value = $urandom;
        send_request(fn, position, value);
    endtask

    // Response side: check accepted items, stall at random
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.status, rsp_ch.data_out, rsp_ch.entry_count);
            rsp_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles without any accepted item
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        sb = new();
        steady  = 1'b0;
        filling = 1'b1;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= FN_READ;
        req_ch.position   <= '0;
        req_ch.entry_data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Errors on the empty list
        send_request(FN_READ,      8'd0,   32'h0);
        send_request(FN_REM_POS,   8'd0,   32'h0);
        send_request(FN_REM_FRONT, 8'd0,   32'h0);
        send_request(FN_REM_END,   8'd0,   32'h0);
        send_request(FN_UNUSED,    8'd255, 32'hFFFF_FFFF);
        send_request(FN_INS_POS,   8'd1,   32'h1234_5678);
        // Build a short list through every insert flavor
        send_request(FN_INS_END,   8'd0,   32'hFFFF_FFFF);
        send_request(FN_INS_FRONT, 8'd0,   32'h0000_0000);
        send_request(FN_INS_POS,   8'd1,   32'hA5A5_A5A5);
        send_request(FN_INS_POS,   8'd3,   32'h5A5A_5A5A);
        send_request(FN_INS_POS,   8'd5,   32'hDEAD_BEEF);
        send_request(FN_INS_POS,   8'd255, 32'hFFFF_FFFF);
        // Read back, then out-of-range reads and removes
        send_request(FN_READ,      8'd0,   32'h0);
        send_request(FN_READ,      8'd1,   32'h0);
        send_request(FN_READ,      8'd2,   32'h0);
        send_request(FN_READ,      8'd3,   32'h0);
        send_request(FN_READ,      8'd4,   32'h0);
        send_request(FN_READ,      8'd255, 32'hFFFF_FFFF);
        send_request(FN_REM_POS,   8'd4,   32'h0);
        // Drain through every remove flavor
        send_request(FN_REM_POS,   8'd1,   32'h0);
        send_request(FN_REM_FRONT, 8'd0,   32'h0);
        send_request(FN_REM_END,   8'd0,   32'h0);
        send_request(FN_REM_POS,   8'd0,   32'h0);
        send_request(FN_REM_END,   8'd0,   32'h0);

        // Random part, with one stretch free of idling
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            steady = (i >= 500 && i < 700);
            send_random_request();
        end
        steady = 1'b0;
        req_ch.valid <= 1'b0;

        while (sb.awaited_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.awaited_responses.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### positional_shift_list.f
design/psl_pkg.sv
design/psl_req_if.sv
design/psl_rsp_if.sv
design/psl_cell.sv
design/psl_collect.sv
design/positional_shift_list.sv
sim/testbench.sv
